/* rtl/indexed_list_insert_remove_assert.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the indexed list
// Shared same-cycle and next-cycle implication property forms, clocked on clk.
// ----------------------------------------------------------------------------
`ifndef INDEXED_LIST_INSERT_REMOVE_ASSERT_SVH
`define INDEXED_LIST_INSERT_REMOVE_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define ILIR_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("indexed list assertion failed");

// Consequent must hold in the cycle after the antecedent.
`define ILIR_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("indexed list assertion failed");

`endif

/* rtl/ilir_pkg.sv */
// ----------------------------------------------------------------------------
// Indexed list package
// Sizes, operation and status codes, and the command broadcast to the cells.
// ----------------------------------------------------------------------------
`default_nettype none

package ilir_pkg;

  localparam int CAPACITY   = 64;
  localparam int DATA_W     = 32;
  localparam int OP_W       = 3;
  localparam int IDX_W      = 7;
  localparam int STATUS_W   = 2;
  localparam int CNT_W      = $clog2(CAPACITY + 1);
  localparam int CMP_W      = (CNT_W > IDX_W) ? CNT_W : IDX_W;
  localparam int GROUP_SIZE = 8;
  localparam int NUM_GROUPS = (CAPACITY + GROUP_SIZE - 1) / GROUP_SIZE;
  localparam int S_TDATA_W  = ((OP_W + IDX_W + DATA_W + 7) / 8) * 8;
  localparam int M_TDATA_W  = ((DATA_W + STATUS_W + IDX_W + 7) / 8) * 8;

  typedef enum logic [OP_W-1:0] {
    OP_APPEND = 3'd0,
    OP_INSERT = 3'd1,
    OP_REMOVE = 3'd2,
    OP_READ   = 3'd3,
    OP_WRITE  = 3'd4
  } op_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK     = 2'd0,
    ST_BOUNDS = 2'd1,
    ST_FULL   = 2'd2
  } status_e;

  typedef enum logic [2:0] {
    CMD_NONE,
    CMD_LOAD,
    CMD_INSERT,
    CMD_REMOVE,
    CMD_READ
  } cmd_kind_e;

  typedef struct packed {
    cmd_kind_e          kind;
    logic [CNT_W-1:0]   idx;
    logic [DATA_W-1:0]  value;
  } cell_cmd_t;

endpackage

`default_nettype wire

/* rtl/ilir_cell.sv */
// ----------------------------------------------------------------------------
// Indexed list cell
// Holds one entry; loads a new value or its neighbor's entry and taps out
// its entry when it is the read target.
// ----------------------------------------------------------------------------
`default_nettype none

module ilir_cell (
  input  wire logic                          clk,
  input  wire ilir_pkg::cell_cmd_t           cmd,
  input  wire logic [ilir_pkg::CNT_W-1:0]    pos,
  input  wire logic [ilir_pkg::DATA_W-1:0]   left_data,
  input  wire logic [ilir_pkg::DATA_W-1:0]   right_data,
  output logic      [ilir_pkg::DATA_W-1:0]   data,
  output logic      [ilir_pkg::DATA_W-1:0]   tap
);
  import ilir_pkg::*;

  logic at_idx;
  logic above_idx;

  assign at_idx    = (pos == cmd.idx);
  assign above_idx = (pos > cmd.idx);
  assign tap       = (cmd.kind == CMD_READ && at_idx) ? data : '0;

  always_ff @(posedge clk) begin
    unique case (cmd.kind)
      CMD_LOAD: begin
        if (at_idx) begin
          data <= cmd.value;
        end
      end
      CMD_INSERT: begin
        if (at_idx) begin
          data <= cmd.value;
        end else if (above_idx) begin
          data <= left_data;
        end
      end
      CMD_REMOVE: begin
        if (at_idx || above_idx) begin
          data <= right_data;
        end
      end
      default: begin
        data <= data;
      end
    endcase
  end

endmodule

`default_nettype wire

/* rtl/indexed_list_insert_remove.sv */
// A request beat is registered in the s1 stage, then in the output register,
// before its result beat appears. A new request is taken only once the single
// stage between the cell row and the output register has passed its request on.
// Insert and remove shift the cells at and above the index in the accepting cycle.
// Reset empties the list and clears both valid flags; entries are not cleared.
// ----------------------------------------------------------------------------
// Indexed list with insert and remove
// Ordered list of signed words held in a row of shifting cells, with append,
// insert, remove, read and write requests.
// ----------------------------------------------------------------------------
`default_nettype none

`include "indexed_list_insert_remove_assert.svh"

module indexed_list_insert_remove (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              s_tvalid,
  output logic                                   s_tready,
  // operation [2:0], index [9:3], value [41:10], zero fill above
  input  wire logic [ilir_pkg::S_TDATA_W-1:0]    s_tdata,
  output logic                                   m_tvalid,
  input  wire logic                              m_tready,
  // read_value [31:0], status [33:32], count [40:34], zero fill above
  output logic      [ilir_pkg::M_TDATA_W-1:0]    m_tdata
);
  import ilir_pkg::*;

  localparam int ROW = NUM_GROUPS * GROUP_SIZE;

  logic                  accept;
  op_e                   op;
  logic [IDX_W-1:0]      in_index;
  logic [DATA_W-1:0]     in_value;
  logic [CMP_W-1:0]      index_ext;
  logic [CMP_W-1:0]      count_ext;
  logic                  full;

  logic [CNT_W-1:0]      cnt;
  logic [CNT_W-1:0]      cnt_next;
  status_e               status_next;
  cell_cmd_t             cmd;

  logic [DATA_W-1:0]     cell_data [CAPACITY];
  logic [DATA_W-1:0]     taps [ROW];
  logic [DATA_W-1:0]     group_or [NUM_GROUPS];

  logic                  s1_valid;
  status_e               s1_status;
  logic [CNT_W-1:0]      s1_count;
  logic [DATA_W-1:0]     s1_group [NUM_GROUPS];
  logic [DATA_W-1:0]     read_or;
  logic                  s1_move;

  logic [DATA_W-1:0]     out_value;
  status_e               out_status;
  logic [CNT_W-1:0]      out_count;

  assign op        = op_e'(s_tdata[OP_W-1:0]);
  assign in_index  = s_tdata[OP_W +: IDX_W];
  assign in_value  = s_tdata[OP_W+IDX_W +: DATA_W];
  assign index_ext = CMP_W'(in_index);
  assign count_ext = CMP_W'(cnt);
  assign full      = (cnt == CNT_W'(CAPACITY));

  assign s_tready  = !s1_valid;
  assign accept    = s_tvalid && s_tready;
  assign s1_move   = s1_valid && (!m_tvalid || m_tready);

  always_comb begin
    cmd.kind    = CMD_NONE;
    cmd.idx     = CNT_W'(in_index);
    cmd.value   = in_value;
    cnt_next    = cnt;
    status_next = ST_OK;
    unique case (op)
      OP_APPEND: begin
        cmd.idx = cnt;
        if (full) begin
          status_next = ST_FULL;
        end else begin
          cmd.kind = CMD_LOAD;
          cnt_next = cnt + CNT_W'(1);
        end
      end
      OP_INSERT: begin
        if (index_ext > count_ext) begin
          status_next = ST_BOUNDS;
        end else if (full) begin
          status_next = ST_FULL;
        end else begin
          cmd.kind = CMD_INSERT;
          cnt_next = cnt + CNT_W'(1);
        end
      end
      OP_REMOVE: begin
        if (index_ext >= count_ext) begin
          status_next = ST_BOUNDS;
        end else begin
          cmd.kind = CMD_REMOVE;
          cnt_next = cnt - CNT_W'(1);
        end
      end
      OP_READ: begin
        if (index_ext >= count_ext) begin
          status_next = ST_BOUNDS;
        end else begin
          cmd.kind = CMD_READ;
        end
      end
      OP_WRITE: begin
        if (index_ext >= count_ext) begin
          status_next = ST_BOUNDS;
        end else begin
          cmd.kind = CMD_LOAD;
        end
      end
      default: begin
        status_next = ST_BOUNDS;
      end
    endcase
    if (!accept) begin
      cmd.kind = CMD_NONE;
    end
  end

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic [DATA_W-1:0] left_in;
    logic [DATA_W-1:0] right_in;
    if (i == 0) begin : g_first
      assign left_in = '0;
    end else begin : g_mid_l
      assign left_in = cell_data[i-1];
    end
    if (i == CAPACITY - 1) begin : g_last
      assign right_in = '0;
    end else begin : g_mid_r
      assign right_in = cell_data[i+1];
    end
    ilir_cell u_cell (
      .clk        (clk),
      .cmd        (cmd),
      .pos        (CNT_W'(i)),
      .left_data  (left_in),
      .right_data (right_in),
      .data       (cell_data[i]),
      .tap        (taps[i])
    );
  end

  for (genvar i = CAPACITY; i < ROW; i++) begin : g_pad
    assign taps[i] = '0;
  end

  always_comb begin
    for (int g = 0; g < NUM_GROUPS; g++) begin
      group_or[g] = '0;
      for (int k = 0; k < GROUP_SIZE; k++) begin
        group_or[g] = group_or[g] | taps[g*GROUP_SIZE + k];
      end
    end
  end

  always_comb begin
    read_or = '0;
    for (int g = 0; g < NUM_GROUPS; g++) begin
      read_or = read_or | s1_group[g];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt      <= '0;
      s1_valid <= 1'b0;
      m_tvalid <= 1'b0;
    end else begin
      if (accept) begin
        cnt      <= cnt_next;
        s1_valid <= 1'b1;
      end else if (s1_move) begin
        s1_valid <= 1'b0;
      end
      if (s1_move) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_status <= status_next;
      s1_count  <= cnt_next;
      s1_group  <= group_or;
    end
    if (s1_move) begin
      out_value  <= read_or;
      out_status <= s1_status;
      out_count  <= s1_count;
    end
  end

  assign m_tdata = M_TDATA_W'({IDX_W'(out_count), out_status, out_value});

  logic [DATA_W-1:0] m_read_value;
  status_e           m_status;
  logic [IDX_W-1:0]  m_count;

  assign m_read_value = m_tdata[DATA_W-1:0];
  assign m_status     = status_e'(m_tdata[DATA_W +: STATUS_W]);
  assign m_count      = m_tdata[DATA_W+STATUS_W +: IDX_W];

  `ILIR_ASSERT_SAME(a_full_at_capacity, m_tvalid && m_status == ST_FULL, m_count == IDX_W'(CAPACITY))
  `ILIR_ASSERT_SAME(a_value_only_on_ok, m_tvalid && m_read_value != '0, m_status == ST_OK)
  `ILIR_ASSERT_NEXT(a_accept_fills_stage, accept, s1_valid && !s_tready)
  `ILIR_ASSERT_NEXT(a_count_holds_idle, !accept, $stable(cnt))
  `ILIR_ASSERT_SAME(a_count_bounded, 1'b1, cnt <= CNT_W'(CAPACITY))

endmodule

`default_nettype wire

/* dv/indexed_list_checker.sv */
// ----------------------------------------------------------------------------
// Indexed list result checker
// Watches the request and result streams of the indexed list. It keeps its
// own copy of the list, predicts the result of every accepted request, and
// compares each result beat in order against the oldest prediction.
// ----------------------------------------------------------------------------
module indexed_list_checker (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           s_tvalid,
  input  wire logic                           s_tready,
  input  wire logic [ilir_pkg::S_TDATA_W-1:0] s_tdata,
  input  wire logic                           m_tvalid,
  input  wire logic                           m_tready,
  input  wire logic [ilir_pkg::M_TDATA_W-1:0] m_tdata,
  output int                                  error_count,
  output int                                  pending
);
  timeunit 1ns;
  timeprecision 1ps;

  import ilir_pkg::*;

  typedef struct packed {
    logic [DATA_W-1:0] read_value;
    status_e           status;
    logic [CNT_W-1:0]  count;
  } list_result_t;

  logic [DATA_W-1:0] list_mem [CAPACITY];
  logic [CNT_W-1:0]  list_len;
  list_result_t      expected_q [$];

  task automatic report_mismatch(input string what, input logic [DATA_W-1:0] got,
                                 input logic [DATA_W-1:0] want);
    error_count++;
    if (error_count <= 40) begin
      $display("checker: %0t ns: %s: got %h, want %h", $time, what, got, want);
    end
  endtask

  function automatic list_result_t apply_request(input logic [OP_W-1:0] op,
                                                 input logic [IDX_W-1:0] idx,
                                                 input logic [DATA_W-1:0] val);
    list_result_t res;
    int pos;
    int len;
    res.read_value = '0;
    res.status     = ST_OK;
    pos = idx;
    len = list_len;
    case (op)
      OP_APPEND: begin
        if (len >= CAPACITY) begin
          res.status = ST_FULL;
        end else begin
          list_mem[len] = val;
          len++;
        end
      end
      OP_INSERT: begin
        if (pos > len) begin
          res.status = ST_BOUNDS;
        end else if (len >= CAPACITY) begin
          res.status = ST_FULL;
        end else begin
          for (int i = len; i > pos; i--) list_mem[i] = list_mem[i-1];
          list_mem[pos] = val;
          len++;
        end
      end
      OP_REMOVE: begin
        if (pos >= len) begin
          res.status = ST_BOUNDS;
        end else begin
          for (int i = pos; i + 1 < len; i++) list_mem[i] = list_mem[i+1];
          list_mem[len-1] = '0;
          len--;
        end
      end
      OP_READ: begin
        if (pos >= len) begin
          res.status = ST_BOUNDS;
        end else begin
          res.read_value = list_mem[pos];
        end
      end
      OP_WRITE: begin
        if (pos >= len) begin
          res.status = ST_BOUNDS;
        end else begin
          list_mem[pos] = val;
        end
      end
      default: begin
        res.status = ST_BOUNDS;
      end
    endcase
    list_len  = CNT_W'(len);
    res.count = list_len;
    return res;
  endfunction

  always @(posedge clk) begin
    list_result_t want;
    if (rst) begin
      list_len = '0;
      expected_q.delete();
    end else begin
      if (s_tvalid && s_tready) begin
        expected_q.push_back(apply_request(s_tdata[2:0], s_tdata[9:3], s_tdata[41:10]));
      end
      if (m_tvalid && m_tready) begin
        if (expected_q.size() == 0) begin
          report_mismatch("result beat with nothing expected", m_tdata[31:0], '0);
        end else begin
          want = expected_q.pop_front();
          if (m_tdata[31:0] !== want.read_value) begin
            report_mismatch("read_value", m_tdata[31:0], want.read_value);
          end
          if (m_tdata[33:32] !== want.status) begin
            report_mismatch("status", DATA_W'(m_tdata[33:32]), DATA_W'(want.status));
          end
          if (m_tdata[40:34] !== want.count) begin
            report_mismatch("count", DATA_W'(m_tdata[40:34]), DATA_W'(want.count));
          end
        end
      end
    end
    pending = expected_q.size();
  end

endmodule

/* dv/tb.sv */
// ----------------------------------------------------------------------------
// Indexed list testbench
// Drives directed and random append, insert, remove, read, write and spare
// opcode requests into the indexed list under several idling patterns on both
// streams, and leaves prediction and comparison to the checker beside the block.
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import ilir_pkg::*;

  localparam logic [OP_W-1:0] OP_SPARE_FIRST = 3'd5;
  localparam logic [OP_W-1:0] OP_SPARE_MID   = 3'd6;
  localparam logic [OP_W-1:0] OP_SPARE_LAST  = 3'd7;
  localparam int              RANDOM_PER_PHASE = 125;

  logic                 clk      = 1'b0;
  logic                 rst      = 1'b1;
  logic                 s_tvalid = 1'b0;
  logic [S_TDATA_W-1:0] s_tdata  = '0;
  logic                 m_tready = 1'b0;
  wire                  s_tready;
  wire                  m_tvalid;
  wire  [M_TDATA_W-1:0] m_tdata;

  int error_count;
  int pending;
  int src_idle_pct  = 0;
  int snk_stall_pct = 0;
  int list_len      = 0;
  int items_sent    = 0;
  int full_hits     = 0;
  bit growing       = 1'b1;

  always #1 clk = ~clk;

  always @(posedge clk) begin
    m_tready <= ($urandom_range(0, 99) >= snk_stall_pct);
  end

  indexed_list_insert_remove u_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  indexed_list_checker u_checker (
    .clk         (clk),
    .rst         (rst),
    .s_tvalid    (s_tvalid),
    .s_tready    (s_tready),
    .s_tdata     (s_tdata),
    .m_tvalid    (m_tvalid),
    .m_tready    (m_tready),
    .m_tdata     (m_tdata),
    .error_count (error_count),
    .pending     (pending)
  );

  task automatic send_req(input logic [OP_W-1:0] op, input logic [IDX_W-1:0] idx,
                          input logic [DATA_W-1:0] val);
    int pos;
    pos = idx;
    if ($urandom_range(0, 99) < src_idle_pct) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {{(S_TDATA_W - OP_W - IDX_W - DATA_W){1'b0}}, val, idx, op};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    items_sent++;
    if (op == OP_APPEND) begin
      if (list_len == CAPACITY) full_hits++;
      else list_len++;
    end else if (op == OP_INSERT && pos <= list_len) begin
      if (list_len == CAPACITY) full_hits++;
      else list_len++;
    end else if (op == OP_REMOVE && pos < list_len) begin
      list_len--;
    end
  endtask

  task automatic send_random();
    int r;
    int hi;
    logic [OP_W-1:0]   op;
    logic [IDX_W-1:0]  idx;
    logic [DATA_W-1:0] val;
    r = $urandom_range(0, 99);
    if (growing) begin
      if (r < 40)      op = OP_APPEND;
      else if (r < 70) op = OP_INSERT;
      else if (r < 80) op = OP_READ;
      else if (r < 90) op = OP_WRITE;
      else if (r < 97) op = OP_REMOVE;
      else             op = OP_W'($urandom_range(OP_SPARE_FIRST, OP_SPARE_LAST));
    end else begin
      if (r < 55)      op = OP_REMOVE;
      else if (r < 65) op = OP_APPEND;
      else if (r < 70) op = OP_INSERT;
      else if (r < 82) op = OP_READ;
      else if (r < 94) op = OP_WRITE;
      else             op = OP_W'($urandom_range(OP_SPARE_FIRST, OP_SPARE_LAST));
    end
    hi = (op == OP_INSERT) ? list_len : list_len - 1;
    if (hi < 0 || $urandom_range(0, 99) < 12) idx = IDX_W'($urandom_range(0, 127));
    else idx = IDX_W'($urandom_range(0, hi));
    if ($urandom_range(0, 9) == 0) begin
      case ($urandom_range(0, 3))
        0: val = 32'h7fff_ffff;
        1: val = 32'h8000_0000;
        2: val = 32'h0000_0000;
        default: val = 32'hffff_ffff;
      endcase
    end else begin
      val = $urandom;
    end
    send_req(op, idx, val);
    if (list_len == CAPACITY && $urandom_range(0, 9) == 0) growing = 1'b0;
    if (list_len == 0) growing = 1'b1;
  endtask

  task automatic drain_results();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    send_req(OP_READ,   7'd0,   32'h0000_0000);
    send_req(OP_REMOVE, 7'd0,   32'h0000_0000);
    send_req(OP_WRITE,  7'd0,   32'h0000_0001);
    send_req(OP_INSERT, 7'd1,   32'h0000_0002);
    send_req(OP_APPEND, 7'd0,   32'h7fff_ffff);
    send_req(OP_APPEND, 7'd0,   32'h8000_0000);
    send_req(OP_INSERT, 7'd0,   32'hffff_ffff);
    send_req(OP_INSERT, 7'd3,   32'h0000_0000);
    send_req(OP_INSERT, 7'd2,   32'h1234_5678);
    send_req(OP_READ,   7'd0,   32'h0000_0000);
    send_req(OP_READ,   7'd4,   32'h0000_0000);
    send_req(OP_READ,   7'd5,   32'h0000_0000);
    send_req(OP_WRITE,  7'd4,   32'haaaa_aaaa);
    send_req(OP_WRITE,  7'd5,   32'h5555_5555);
    send_req(OP_READ,   7'd127, 32'hffff_ffff);
    send_req(OP_REMOVE, 7'd0,   32'h0000_0000);
    send_req(OP_REMOVE, 7'd3,   32'h0000_0000);
    send_req(OP_REMOVE, 7'd3,   32'h0000_0000);
    send_req(OP_READ,   7'd2,   32'h0000_0000);
    send_req(OP_SPARE_FIRST, 7'd127, 32'hffff_ffff);
    send_req(OP_SPARE_MID,   7'd64,  32'h0000_0000);
    send_req(OP_SPARE_LAST,  7'd127, 32'hffff_ffff);
    send_req(OP_REMOVE, 7'd1,   32'h0000_0000);
    send_req(OP_READ,   7'd1,   32'h0000_0000);
    drain_results();

    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin src_idle_pct = 0;  snk_stall_pct = 0;  end
        1: begin src_idle_pct = 48; snk_stall_pct = 0;  end
        2: begin src_idle_pct = 0;  snk_stall_pct = 48; end
        default: begin src_idle_pct = 26; snk_stall_pct = 26; end
      endcase
      repeat (RANDOM_PER_PHASE) send_random();
      drain_results();
    end

    $display("tb: %0d requests sent over four idling patterns", items_sent);
    $display("tb: %0d adds refused on a full list", full_hits);
    if (error_count == 0) begin
      $display("tb: done, clean");
    end else begin
      $display("tb: done, errors");
    end
    $finish;
  end

  initial begin
    #400_000;
    $display("tb: done, errors");
    $finish;
  end

endmodule
